[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the ramp builder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define GRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("grb assertion failed");

// Checked on every clock edge, reset included.
`define GRB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("grb assertion failed");

`endif

[src/grb_pkg.sv]
// ----------------------------------------------------------------------------
// Gradient ramp builder package
// Widths, constants and shared types of the gradient ramp builder.
// ----------------------------------------------------------------------------
`default_nettype none

package grb_pkg;

    localparam int MAX_RAMP_DEF = 64;
    localparam int LEN_W        = 7;
    localparam int IDX_W        = 6;
    localparam int OFF_W        = 17;
    localparam int FRAC_W       = 16;
    localparam int COL_W        = 8;
    localparam int NCH          = 4;
    localparam int CH_W         = 2;
    localparam int DCNT_W       = 3;

    localparam logic [OFF_W-1:0] OFF_ONE         = 17'h10000;
    localparam logic [LEN_W-1:0] RAMP_LENGTH_RST = 7'd64;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address.
    localparam logic REG_RAMP_LENGTH = 1'b0;

    typedef logic [NCH-1:0][COL_W-1:0] t_color;

    typedef struct packed {
        logic             start;
        logic [COL_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] quo;
        logic [LEN_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

[src/grb_cfg.sv]
// ----------------------------------------------------------------------------
// Gradient ramp builder configuration registers
// APB-style register file holding the ramp length.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [grb_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [grb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [grb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready,
    output logic      [grb_pkg::LEN_W-1:0]           o_ramp_length
);

    logic [grb_pkg::LEN_W-1:0] r_ramp_length;
    logic                      hit;

    assign hit = (paddr[grb_pkg::APB_ADDR_W-1] == grb_pkg::REG_RAMP_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_length <= grb_pkg::RAMP_LENGTH_RST;
        end else if (psel && penable && pwrite && hit) begin
            r_ramp_length <= pwdata[grb_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = {{(grb_pkg::APB_DATA_W-grb_pkg::LEN_W){1'b0}}, r_ramp_length};
        end
    end

    assign pready        = 1'b1;
    assign o_ramp_length = r_ramp_length;

endmodule

`default_nettype wire

[src/grb_div.sv]
// ----------------------------------------------------------------------------
// Gradient ramp builder slope divider
// Restoring divider, one quotient bit per cycle, shared by all channels.
// ----------------------------------------------------------------------------
`default_nettype none

module grb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire grb_pkg::t_div_req i_req,
    output grb_pkg::t_div_rsp      o_rsp
);

    logic [grb_pkg::LEN_W-1:0]  r_rem, n_rem;
    logic [grb_pkg::COL_W-1:0]  r_quo, n_quo;
    logic [grb_pkg::LEN_W-1:0]  r_dvs, n_dvs;
    logic [grb_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [grb_pkg::LEN_W:0]    shifted;
    logic                       ge;

    assign shifted = {r_rem, r_quo[grb_pkg::COL_W-1]};
    assign ge      = (shifted >= {1'b0, r_dvs});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so it fits LEN_W bits.
            n_rem = ge ? grb_pkg::LEN_W'(shifted - {1'b0, r_dvs})
                       : grb_pkg::LEN_W'(shifted);
            n_quo = {r_quo[grb_pkg::COL_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == grb_pkg::DCNT_W'(grb_pkg::COL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

[src/gradient_ramp_builder.sv]
// ----------------------------------------------------------------------------
// Gradient ramp builder
// Turns a stream of gradient stops into RGBA ramp entries.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Moves
//  stop     in         i_valid / o_stall    one gradient stop per transaction
//  entry    out        o_valid / i_stall    one ramp entry per transaction
//  config   in         APB (psel, penable)  ramp_length register
//
// After a stop transaction, state S_MUL scales the clamped offset to an entry index
// and S_SETUP sets up the run. If the stop interpolates entries, the shared
// divider then works out the slope for each of the four channels in turn.
// Entries then leave one per cycle while the output register is free, at most 64.
// The stop port stalls until the last entry of a stop is in the output register.
// Reset clears the stop history and sets ramp_length to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_ramp_builder #(
    parameter int MAX_RAMP = grb_pkg::MAX_RAMP_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [grb_pkg::OFF_W-1:0]       i_stop_offset,
    input  wire logic [grb_pkg::COL_W-1:0]       i_stop_red,
    input  wire logic [grb_pkg::COL_W-1:0]       i_stop_green,
    input  wire logic [grb_pkg::COL_W-1:0]       i_stop_blue,
    input  wire logic [grb_pkg::COL_W-1:0]       i_stop_alpha,
    input  wire logic                            i_final_stop,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [grb_pkg::IDX_W-1:0]       o_entry_index,
    output logic      [grb_pkg::COL_W-1:0]       o_out_red,
    output logic      [grb_pkg::COL_W-1:0]       o_out_green,
    output logic      [grb_pkg::COL_W-1:0]       o_out_blue,
    output logic      [grb_pkg::COL_W-1:0]       o_out_alpha,
    output logic                                 o_run_end,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [grb_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [grb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [grb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int LEN_W = grb_pkg::LEN_W;
    localparam int OFF_W = grb_pkg::OFF_W;
    localparam int COL_W = grb_pkg::COL_W;
    localparam int NCH   = grb_pkg::NCH;
    localparam int CH_W  = grb_pkg::CH_W;
    localparam int PRD_W = LEN_W + OFF_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MUL      = 7'b0000010,
        S_SETUP    = 7'b0000100,
        S_DIV_GO   = 7'b0001000,
        S_DIV_WAIT = 7'b0010000,
        S_INTERP   = 7'b0100000,
        S_FILL     = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Stop history.
    logic                  r_have_stop, n_have_stop;
    logic [OFF_W-1:0]      r_prev_offset, n_prev_offset;
    logic [LEN_W-1:0]      r_prev_index, n_prev_index;
    grb_pkg::t_color       r_prev_col, n_prev_col;

    // Current stop.
    logic [OFF_W-1:0]      r_off, n_off;
    grb_pkg::t_color       r_dst, n_dst;
    logic                  r_fin, n_fin;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [LEN_W-1:0]      r_idx, n_idx;
    logic [LEN_W-1:0]      r_cur, n_cur;
    logic [LEN_W-1:0]      r_n, n_n;
    logic [CH_W-1:0]       r_ch, n_ch;

    // Channel lanes: value, remainder, and the slope split into q and r parts.
    logic signed [COL_W:0]   r_d  [NCH];
    logic signed [COL_W:0]   n_d  [NCH];
    logic signed [COL_W+1:0] r_q  [NCH];
    logic signed [COL_W+1:0] n_q  [NCH];
    logic [LEN_W-1:0]        r_r  [NCH];
    logic [LEN_W-1:0]        n_r  [NCH];
    logic signed [COL_W:0]   r_qd [NCH];
    logic signed [COL_W:0]   n_qd [NCH];
    logic [LEN_W-1:0]        r_rd [NCH];
    logic [LEN_W-1:0]        n_rd [NCH];

    // Output register.
    logic                     r_ov, n_ov;
    logic [grb_pkg::IDX_W-1:0] r_o_idx, n_o_idx;
    grb_pkg::t_color          r_o_col, n_o_col;
    logic                     r_o_end, n_o_end;

    logic [LEN_W-1:0]      ramp_length;
    logic [OFF_W-1:0]      off_clamped;
    logic [OFF_W-1:0]      off_eff;
    logic [LEN_W-1:0]      len_eff;
    logic [PRD_W-1:0]      prod;
    logic [LEN_W-1:0]      base;
    grb_pkg::t_color       base_col;
    logic                  slot_free;
    logic                  fill_after;
    logic                  last_interp;
    logic signed [COL_W:0] dsel;
    logic [COL_W:0]        dmag;
    logic [COL_W:0]        qd_pos;
    logic [LEN_W:0]        rsum [NCH];
    logic                  carry [NCH];

    grb_pkg::t_div_req div_req;
    grb_pkg::t_div_rsp div_rsp;

    grb_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_ramp_length (ramp_length)
    );

    grb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_stall = (r_state != S_IDLE);

    assign off_clamped = (i_stop_offset > grb_pkg::OFF_ONE) ? grb_pkg::OFF_ONE
                                                            : i_stop_offset;
    assign off_eff = (r_have_stop && (off_clamped < r_prev_offset)) ? r_prev_offset
                                                                   : off_clamped;

    always_comb begin
        if (ramp_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (ramp_length > LEN_W'(MAX_RAMP)) begin
            len_eff = LEN_W'(MAX_RAMP);
        end else begin
            len_eff = ramp_length;
        end
    end

    assign prod = PRD_W'(r_len) * PRD_W'(r_off);

    // The first stop of a gradient acts as its own predecessor.
    assign base     = r_have_stop ? r_prev_index : '0;
    assign base_col = r_have_stop ? r_prev_col : r_dst;

    assign slot_free   = !r_ov || !i_stall;
    assign fill_after  = r_fin && (r_idx < r_len);
    assign last_interp = (r_cur == (r_idx - 1'b1));

    assign dsel   = r_d[r_ch];
    assign dmag   = dsel[COL_W] ? (COL_W+1)'(-dsel) : (COL_W+1)'(dsel);
    assign qd_pos = {1'b0, div_rsp.quo};

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            rsum[c]  = {1'b0, r_r[c]} + {1'b0, r_rd[c]};
            carry[c] = (rsum[c] >= {1'b0, r_n});
        end
    end

    always_comb begin
        n_state       = r_state;
        n_have_stop   = r_have_stop;
        n_prev_offset = r_prev_offset;
        n_prev_index  = r_prev_index;
        n_prev_col    = r_prev_col;
        n_off         = r_off;
        n_dst         = r_dst;
        n_fin         = r_fin;
        n_len         = r_len;
        n_idx         = r_idx;
        n_cur         = r_cur;
        n_n           = r_n;
        n_ch          = r_ch;
        n_d           = r_d;
        n_q           = r_q;
        n_r           = r_r;
        n_qd          = r_qd;
        n_rd          = r_rd;
        n_ov          = r_ov && i_stall;
        n_o_idx       = r_o_idx;
        n_o_col       = r_o_col;
        n_o_end       = r_o_end;

        div_req.start    = 1'b0;
        div_req.dividend = dmag[COL_W-1:0];
        div_req.divisor  = r_n;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_off   = off_eff;
                    n_dst   = {i_stop_alpha, i_stop_blue, i_stop_green, i_stop_red};
                    n_fin   = i_final_stop;
                    n_len   = len_eff;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_idx   = prod[grb_pkg::FRAC_W +: LEN_W];
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_cur = base;
                if (r_idx > base) begin
                    n_n  = r_idx - base;
                    n_ch = '0;
                    for (int c = 0; c < NCH; c++) begin
                        n_d[c] = $signed({1'b0, r_dst[c]}) - $signed({1'b0, base_col[c]});
                        n_q[c] = $signed({2'b00, base_col[c]});
                        n_r[c] = '0;
                    end
                    n_state = S_DIV_GO;
                end else if (fill_after) begin
                    n_cur   = r_idx;
                    n_state = S_FILL;
                end else begin
                    n_state = S_IDLE;
                end
                // The history moves on now; the lanes already hold what they need.
                n_prev_col    = r_dst;
                n_prev_index  = r_fin ? '0 : r_idx;
                n_prev_offset = r_fin ? '0 : r_off;
                n_have_stop   = !r_fin;
            end
            S_DIV_GO: begin
                div_req.start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    // Turn the magnitude quotient into a floor quotient with a
                    // remainder in 0..n-1.
                    if (!dsel[COL_W]) begin
                        n_qd[r_ch] = $signed(qd_pos);
                        n_rd[r_ch] = div_rsp.rem;
                    end else if (div_rsp.rem == '0) begin
                        n_qd[r_ch] = $signed(~qd_pos + 1'b1);
                        n_rd[r_ch] = '0;
                    end else begin
                        n_qd[r_ch] = $signed(~qd_pos);
                        n_rd[r_ch] = r_n - div_rsp.rem;
                    end
                    if (r_ch == CH_W'(NCH - 1)) begin
                        n_state = S_INTERP;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_INTERP: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_o_idx = r_cur[grb_pkg::IDX_W-1:0];
                    for (int c = 0; c < NCH; c++) begin
                        n_o_col[c] = r_q[c][COL_W-1:0];
                        n_r[c]     = carry[c] ? LEN_W'(rsum[c] - {1'b0, r_n})
                                              : LEN_W'(rsum[c]);
                        n_q[c]     = r_q[c] + {r_qd[c][COL_W], r_qd[c]}
                                   + {{(COL_W+1){1'b0}}, carry[c]};
                    end
                    n_o_end = last_interp && !fill_after;
                    n_cur   = r_cur + 1'b1;
                    if (last_interp) begin
                        n_state = fill_after ? S_FILL : S_IDLE;
                    end
                end
            end
            S_FILL: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_o_idx = r_cur[grb_pkg::IDX_W-1:0];
                    n_o_col = r_dst;
                    n_o_end = (r_cur == (r_len - 1'b1));
                    n_cur   = r_cur + 1'b1;
                    if (r_cur == (r_len - 1'b1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_have_stop   <= 1'b0;
            r_prev_offset <= '0;
            r_prev_index  <= '0;
            r_prev_col    <= '0;
            r_ov          <= 1'b0;
            r_ch          <= '0;
        end else begin
            r_state       <= n_state;
            r_have_stop   <= n_have_stop;
            r_prev_offset <= n_prev_offset;
            r_prev_index  <= n_prev_index;
            r_prev_col    <= n_prev_col;
            r_ov          <= n_ov;
            r_ch          <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off   <= n_off;
        r_dst   <= n_dst;
        r_fin   <= n_fin;
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_n     <= n_n;
        r_d     <= n_d;
        r_q     <= n_q;
        r_r     <= n_r;
        r_qd    <= n_qd;
        r_rd    <= n_rd;
        r_o_idx <= n_o_idx;
        r_o_col <= n_o_col;
        r_o_end <= n_o_end;
    end

    assign o_valid       = r_ov;
    assign o_entry_index = r_o_idx;
    assign o_out_red     = r_o_col[0];
    assign o_out_green   = r_o_col[1];
    assign o_out_blue    = r_o_col[2];
    assign o_out_alpha   = r_o_col[3];
    assign o_run_end     = r_o_end;

endmodule

`default_nettype wire

[src/grb_checker.sv]
// ----------------------------------------------------------------------------
// Gradient ramp builder port checker
// Watches the top-level ports for ordering and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grb_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_stall,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic [grb_pkg::IDX_W-1:0] o_entry_index,
    input wire logic                      o_run_end
);

    property p_out_hold;
        o_valid && i_stall |=> o_valid && $stable(o_entry_index);
    endproperty

    property p_idx_step;
        (o_valid && !i_stall && !o_run_end) ##1 o_valid
            |-> (o_entry_index == $past(o_entry_index) + 1'b1);
    endproperty

    // A stalled entry holds its place.
    `GRB_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold)

    // A stop transaction always starts work, so the port stalls right after.
    `GRB_ASSERT(a_in_busy, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)

    // Entries of one run follow each other in index order.
    `GRB_ASSERT(a_idx_step, i_clk, i_rst_n, p_idx_step)

    // Reset leaves nothing pending on either side.
    `GRB_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

bind gradient_ramp_builder grb_checker u_grb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_entry_index (o_entry_index),
    .o_run_end     (o_run_end)
);

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Gradient ramp builder testbench
// Sends gradient stops through the stop port with bursty timing and checks
// every ramp entry against an in-bench model of the ramp interpolation, or a
// typed plan row's own entries. A short directed plan runs first. Random gradients
// and loose stops follow over a range of ramp lengths, set via APB while idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int OFF_W        = grb_pkg::OFF_W;
    localparam int COL_W        = grb_pkg::COL_W;
    localparam int IDX_W        = grb_pkg::IDX_W;
    localparam int LEN_W        = grb_pkg::LEN_W;
    localparam int NCH          = grb_pkg::NCH;
    localparam int FRAC_W       = grb_pkg::FRAC_W;
    localparam int MAX_RAMP_DEF = grb_pkg::MAX_RAMP_DEF;
    localparam int APB_ADDR_W   = grb_pkg::APB_ADDR_W;
    localparam int APB_DATA_W   = grb_pkg::APB_DATA_W;

    localparam logic [OFF_W-1:0] OFF_ONE         = grb_pkg::OFF_ONE;
    localparam logic [LEN_W-1:0] RAMP_LENGTH_RST = grb_pkg::RAMP_LENGTH_RST;

    typedef grb_pkg::t_color t_color;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PLAN_ROWS     = 18;

    // Channel positions inside t_color, so a 32'hRRGGBBAA literal reads naturally.
    localparam int CH_RED   = 3;
    localparam int CH_GREEN = 2;
    localparam int CH_BLUE  = 1;
    localparam int CH_ALPHA = 0;

    localparam logic [APB_ADDR_W-1:0] LENGTH_ADDR = {grb_pkg::REG_RAMP_LENGTH, 2'b00};

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        t_color           color;
        logic             final_stop;
    } t_stop;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        t_color           color;
        logic             run_end;
    } t_entry;

    // A typed row expects entries lo .. hi-1, all in the stop's own color.
    typedef struct packed {
        logic             set_len;
        logic [LEN_W-1:0] len_value;
        t_stop            stop;
        logic             typed;
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] hi;
    } t_plan_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_EVERY_THIRD,
        STALL_HEAVY
    } t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [OFF_W-1:0]      i_stop_offset;
    logic [COL_W-1:0]      i_stop_red;
    logic [COL_W-1:0]      i_stop_green;
    logic [COL_W-1:0]      i_stop_blue;
    logic [COL_W-1:0]      i_stop_alpha;
    logic                  i_final_stop;
    logic                  o_valid;
    logic                  i_stall;
    logic [IDX_W-1:0]      o_entry_index;
    logic [COL_W-1:0]      o_out_red;
    logic [COL_W-1:0]      o_out_green;
    logic [COL_W-1:0]      o_out_blue;
    logic [COL_W-1:0]      o_out_alpha;
    logic                  o_run_end;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gradient_ramp_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stop_offset (i_stop_offset),
        .i_stop_red    (i_stop_red),
        .i_stop_green  (i_stop_green),
        .i_stop_blue   (i_stop_blue),
        .i_stop_alpha  (i_stop_alpha),
        .i_final_stop  (i_final_stop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_entry_index (o_entry_index),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .o_run_end     (o_run_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Model state of the ramp builder.
    logic [LEN_W-1:0] ramp_len;
    logic             grad_open;
    logic [OFF_W-1:0] prior_offset;
    logic [LEN_W-1:0] last_index;
    t_color           last_color;

    t_entry      pending_entries[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          hold_request = 1'b0;

    t_plan_row directed_plan [PLAN_ROWS] = '{
        '{1'b0, 7'd0,   '{17'h00000, 32'hFF0080FF, 1'b1}, 1'b1, 7'd0,  7'd64},
        '{1'b0, 7'd0,   '{17'h1FFFF, 32'h01020304, 1'b1}, 1'b1, 7'd0,  7'd64},
        '{1'b0, 7'd0,   '{17'h10000, 32'h00000000, 1'b0}, 1'b1, 7'd0,  7'd64},
        '{1'b0, 7'd0,   '{17'h00000, 32'hFFFFFFFF, 1'b1}, 1'b1, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h00000, 32'h00000000, 1'b0}, 1'b1, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h08000, 32'hFFFFFFFF, 1'b0}, 1'b0, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h04000, 32'h12345678, 1'b0}, 1'b0, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h10000, 32'hAA55AA55, 1'b1}, 1'b0, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h00001, 32'h00FF00FF, 1'b0}, 1'b1, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h00400, 32'hFF00FF00, 1'b0}, 1'b0, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h0C000, 32'h80808080, 1'b1}, 1'b0, 7'd0,  7'd0},
        '{1'b1, 7'd1,   '{17'h1FFFF, 32'h7F7F7F7F, 1'b1}, 1'b1, 7'd0,  7'd1},
        '{1'b1, 7'd0,   '{17'h08000, 32'h5A5A5A5A, 1'b1}, 1'b1, 7'd0,  7'd1},
        '{1'b1, 7'd127, '{17'h10000, 32'hC3C3C3C3, 1'b1}, 1'b1, 7'd0,  7'd64},
        '{1'b0, 7'd0,   '{17'h0F000, 32'h11223344, 1'b0}, 1'b1, 7'd0,  7'd60},
        '{1'b1, 7'd8,   '{17'h0F800, 32'h99887766, 1'b1}, 1'b0, 7'd0,  7'd0},
        '{1'b1, 7'd64,  '{17'h00000, 32'h00FF00FF, 1'b0}, 1'b1, 7'd0,  7'd0},
        '{1'b0, 7'd0,   '{17'h10000, 32'hFF00FF00, 1'b1}, 1'b0, 7'd0,  7'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Works out the ramp entries one stop produces and advances the model state.
    function automatic void build_ramp_entries(input t_stop s, input bit keep);
        int unsigned len, off, idx, span, i, j, c;
        t_entry      e;
        t_entry      run[$];
        len = ramp_len;
        if (len < 1) len = 1;
        if (len > MAX_RAMP_DEF) len = MAX_RAMP_DEF;
        off = s.offset;
        if (off > OFF_ONE) off = OFF_ONE;
        if (grad_open && off < prior_offset) off = prior_offset;
        // The first stop of a gradient is its own predecessor.
        if (!grad_open) begin
            last_index = '0;
            last_color = s.color;
        end
        idx = (len * off) >> FRAC_W;
        if (idx > last_index) begin
            span = idx - last_index;
            for (i = last_index; i < idx; i++) begin
                j = i - last_index;
                e.index = IDX_W'(i);
                for (c = 0; c < NCH; c++) begin
                    e.color[c] = COL_W'((last_color[c] * (span - j) + s.color[c] * j) / span);
                end
                e.run_end = 1'b0;
                run.push_back(e);
            end
        end
        if (s.final_stop) begin
            for (i = idx; i < len; i++) begin
                e.index   = IDX_W'(i);
                e.color   = s.color;
                e.run_end = 1'b0;
                run.push_back(e);
            end
        end
        if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
        last_color   = s.color;
        last_index   = LEN_W'(idx);
        prior_offset = OFF_W'(off);
        grad_open    = !s.final_stop;
        if (s.final_stop) begin
            prior_offset = '0;
            last_index   = '0;
        end
        if (keep) begin
            foreach (run[k]) pending_entries.push_back(run[k]);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic t_color random_color();
        t_color v;
        for (int c = 0; c < NCH; c++) begin
            case ($urandom_range(0, 7))
                0: v[c] = '0;
                1: v[c] = '1;
                default: v[c] = COL_W'($urandom_range(0, 255));
            endcase
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_entry want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected entry, expected none, actual index %0d",
                         $time, o_entry_index);
                mismatches++;
            end else begin
                want = pending_entries.pop_front();
                check_field("entry_index", want.index, o_entry_index);
                check_field("out_red", want.color[CH_RED], o_out_red);
                check_field("out_green", want.color[CH_GREEN], o_out_green);
                check_field("out_blue", want.color[CH_BLUE], o_out_blue);
                check_field("out_alpha", want.color[CH_ALPHA], o_out_alpha);
                check_field("run_end", want.run_end, o_run_end);
            end
        end
    end

    // Entry receiver: shifting stall patterns, plus one long hold-off on request.
    initial begin
        int          hold_left;
        int          mode_left;
        int unsigned tick;
        t_stall_mode mode;
        i_stall   = 1'b0;
        hold_left = 0;
        mode_left = 0;
        tick      = 0;
        mode      = STALL_NONE;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:        i_stall = 1'b0;
                    STALL_SPARSE:      i_stall = ($urandom_range(0, 4) == 0);
                    STALL_EVERY_THIRD: i_stall = (tick % 3 == 0);
                    default:           i_stall = ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Offers one stop, in bursts with random gaps while gaps are on, and waits for the transaction.
    task automatic send_stop(input t_stop s, input bit keep);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_valid = 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_stop_offset = s.offset;
        i_stop_red    = s.color[CH_RED];
        i_stop_green  = s.color[CH_GREEN];
        i_stop_blue   = s.color[CH_BLUE];
        i_stop_alpha  = s.color[CH_ALPHA];
        i_final_stop  = s.final_stop;
        i_valid       = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        build_ramp_entries(s, keep);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        // A stop may produce no entries and still be in flight.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_read(output logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = LENGTH_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        value = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_ramp_length(input logic [LEN_W-1:0] len);
        logic [APB_DATA_W-1:0] got;
        wait_idle();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = LENGTH_ADDR;
        pwdata  = APB_DATA_W'(len);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        ramp_len = len;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        apb_read(got);
        check_field("ramp_length readback", len, got);
    endtask

    // Mostly well-formed gradients with random content, some loose stops.
    task automatic run_random_stops(input int count);
        int          sent;
        int          stops;
        int unsigned cur;
        t_stop       s;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) != 0) begin
                stops = $urandom_range(2, 5);
                cur   = $urandom_range(0, 16384);
                for (int k = 0; k < stops; k++) begin
                    s.offset     = OFF_W'(cur);
                    s.color      = random_color();
                    s.final_stop = (k == stops - 1);
                    if (s.final_stop && $urandom_range(0, 3) == 0) s.offset = OFF_ONE;
                    send_stop(s, 1'b1);
                    sent++;
                    cur = cur + $urandom_range(0, (OFF_ONE - cur) * 2 / (stops - k));
                    if (cur > OFF_ONE) cur = OFF_ONE;
                end
            end else begin
                s.offset     = OFF_W'($urandom_range(0, 131071));
                s.color      = random_color();
                s.final_stop = 1'($urandom_range(0, 1));
                send_stop(s, 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        logic [APB_DATA_W-1:0] got;
        logic [LEN_W-1:0]      len;
        logic [LEN_W-1:0]      edge_lengths [6];
        t_entry                e;
        edge_lengths  = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd64};
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stop_offset = '0;
        i_stop_red    = '0;
        i_stop_green  = '0;
        i_stop_blue   = '0;
        i_stop_alpha  = '0;
        i_final_stop  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        ramp_len      = RAMP_LENGTH_RST;
        grad_open     = 1'b0;
        prior_offset  = '0;
        last_index    = '0;
        last_color    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_read(got);
        check_field("ramp_length after reset", RAMP_LENGTH_RST, got);

        foreach (directed_plan[r]) begin
            if (directed_plan[r].set_len) set_ramp_length(directed_plan[r].len_value);
            send_stop(directed_plan[r].stop, !directed_plan[r].typed);
            if (directed_plan[r].typed) begin
                for (int i = directed_plan[r].lo; i < directed_plan[r].hi; i++) begin
                    e.index   = IDX_W'(i);
                    e.color   = directed_plan[r].stop.color;
                    e.run_end = (i == directed_plan[r].hi - 1);
                    pending_entries.push_back(e);
                end
            end
        end

        for (int p = 0; p < 12; p++) begin
            if (p < 6) begin
                len = edge_lengths[p];
            end else if ($urandom_range(0, 3) == 0) begin
                len = LEN_W'($urandom_range(0, 127));
            end else begin
                len = LEN_W'($urandom_range(1, 16));
            end
            set_ramp_length(len);
            gaps_on = ($urandom_range(0, 3) != 0);
            // Full-length ramps behind a long output hold-off back up into the stop port.
            if (p == 2) hold_request = 1'b1;
            if (p == 4) begin
                run_random_stops(10);
                wait_idle();
                run_random_stops(10);
            end else begin
                run_random_stops(20);
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
